[rtl/core/iol_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_pkg
// Shared types and constants for the indexed ordered list.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;
  localparam int POS_W     = 11;   // holds any position up to the largest depth
  localparam int GRP       = 8;    // entries per first-level read group
  localparam int GRP_W     = 3;
  localparam int NGRP      = 8;    // groups that the index can reach
  localparam int NGRP_W    = 3;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             load;   // cell at pos takes the new value
    logic             up;     // cells above pos take their lower neighbor
    logic             dn;     // cells at or above pos take their upper neighbor
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

[rtl/core/iol_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_cell
// One list slot: holds an entry and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module iol_cell #(
  parameter int Pos = 0
) (
  input  logic                           clk_i,
  input  iol_pkg::cell_cmd_t             cmd_i,
  input  logic [iol_pkg::VAL_W-1:0]      value_i,
  input  logic [iol_pkg::VAL_W-1:0]      prev_i,
  input  logic [iol_pkg::VAL_W-1:0]      next_i,
  output logic [iol_pkg::VAL_W-1:0]      entry_o
);

  localparam logic [iol_pkg::POS_W-1:0] MyPos = iol_pkg::POS_W'(Pos);

  logic [iol_pkg::VAL_W-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.load && (MyPos == cmd_i.pos)) begin
      entry_d = value_i;
    end else if (cmd_i.up && (MyPos > cmd_i.pos)) begin
      entry_d = prev_i;
    end else if (cmd_i.dn && (MyPos >= cmd_i.pos)) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/core/iol_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_ctrl
// Command decode, range and fullness checks, and the entry count.
// ----------------------------------------------------------------------------
module iol_ctrl #(
  parameter int Depth = iol_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [2:0]                    kind_i,
  input  logic [iol_pkg::IDX_W-1:0]     index_i,
  output iol_pkg::cell_cmd_t            cmd_o,
  output iol_pkg::status_e              status_o,
  output logic                          rd_ok_o,
  output logic [iol_pkg::CNT_OUT_W-1:0] count_o
);

  localparam int CntW = $clog2(Depth + 1);
  localparam int CmpW = (CntW > iol_pkg::IDX_W) ? CntW : iol_pkg::IDX_W;
  localparam int OutW = (CntW > iol_pkg::CNT_OUT_W) ? CntW : iol_pkg::CNT_OUT_W;

  logic [CntW-1:0]    count_q, count_d;
  logic [CmpW-1:0]    cmp_idx, cmp_cnt;
  logic [OutW-1:0]    cnt_wide;
  logic               full;
  logic               in_range;
  iol_pkg::cell_cmd_t cmd;

  assign cmp_idx  = CmpW'(index_i);
  assign cmp_cnt  = CmpW'(count_q);
  assign in_range = cmp_idx < cmp_cnt;
  assign full     = count_q == CntW'(Depth);

  always_comb begin
    cmd      = '0;
    status_o = iol_pkg::ST_DONE;
    rd_ok_o  = 1'b0;
    count_d  = count_q;
    case (kind_i)
      iol_pkg::KIND_APPEND: begin
        if (full) begin
          status_o = iol_pkg::ST_FULL;
        end else begin
          cmd.load = 1'b1;
          cmd.pos  = iol_pkg::POS_W'(count_q);
          count_d  = count_q + CntW'(1);
        end
      end
      iol_pkg::KIND_REMOVE: begin
        if (!in_range) begin
          status_o = iol_pkg::ST_RANGE;
        end else begin
          cmd.dn  = 1'b1;
          cmd.pos = iol_pkg::POS_W'(index_i);
          count_d = count_q - CntW'(1);
        end
      end
      iol_pkg::KIND_INSERT: begin
        // empty list: only index 0 is taken, as an append
        if (count_q == '0) begin
          if (index_i != '0) begin
            status_o = iol_pkg::ST_RANGE;
          end else begin
            cmd.load = 1'b1;
            cmd.pos  = '0;
            count_d  = CntW'(1);
          end
        end else if (!in_range) begin
          status_o = iol_pkg::ST_RANGE;
        end else if (full) begin
          status_o = iol_pkg::ST_FULL;
        end else begin
          cmd.load = 1'b1;
          cmd.up   = 1'b1;
          cmd.pos  = iol_pkg::POS_W'(index_i) + iol_pkg::POS_W'(1);
          count_d  = count_q + CntW'(1);
        end
      end
      iol_pkg::KIND_CLEAR: begin
        count_d = '0;
      end
      iol_pkg::KIND_READ: begin
        if (!in_range) begin
          status_o = iol_pkg::ST_RANGE;
        end else begin
          rd_ok_o = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_o = accept_i ? cmd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign cnt_wide = OutW'(count_q);
  assign count_o  = cnt_wide[iol_pkg::CNT_OUT_W-1:0];

endmodule

[rtl/core/indexed_ordered_list_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_top
// Ordered list of signed entries kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// the result strobe done_o follows a taken request through pend_q, then done_q
// busy holds off a new request while pend_q is set, the time taken by the final
//   level of the registered read select over the cells
// the receiver cannot stall; done_o is high for one cycle only, and the result registers hold until the next request
// reset clears the count and the control state; entry contents are not reset
module indexed_ordered_list_top #(
  parameter int Depth = iol_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    kind_i,
  input  logic [iol_pkg::IDX_W-1:0]     index_i,
  input  logic [iol_pkg::VAL_W-1:0]     value_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [iol_pkg::VAL_W-1:0]     read_value_o,
  output logic [iol_pkg::CNT_OUT_W-1:0] entry_count_o
);

  logic                          accept;
  iol_pkg::cell_cmd_t            cmd;
  iol_pkg::status_e              status;
  logic                          rd_ok;
  logic [iol_pkg::CNT_OUT_W-1:0] count;

  logic [iol_pkg::VAL_W-1:0] cell_val [Depth];
  logic [iol_pkg::VAL_W-1:0] rd_src   [iol_pkg::NGRP][iol_pkg::GRP];
  logic [iol_pkg::VAL_W-1:0] grp_q    [iol_pkg::NGRP];

  logic                          pend_q;
  logic                          rd_ok_q;
  logic [1:0]                    st_q;
  logic [iol_pkg::NGRP_W-1:0]    hi_q;
  logic                          done_q;
  logic [1:0]                    status_q;
  logic [iol_pkg::VAL_W-1:0]     rdval_q;
  logic [iol_pkg::CNT_OUT_W-1:0] cnt_q;

  assign accept = start && !busy;
  assign busy   = pend_q;

  iol_ctrl #(
    .Depth (Depth)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (kind_i),
    .index_i  (index_i),
    .cmd_o    (cmd),
    .status_o (status),
    .rd_ok_o  (rd_ok),
    .count_o  (count)
  );

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [iol_pkg::VAL_W-1:0] prev, next;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid_lo
      assign prev = cell_val[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign next = '0;
    end else begin : g_mid_hi
      assign next = cell_val[i+1];
    end
    iol_cell #(
      .Pos (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .value_i (value_i),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (cell_val[i])
    );
  end

  // first read level: each group picks its entry by the low index bits
  for (genvar g = 0; g < iol_pkg::NGRP; g++) begin : g_grp
    for (genvar j = 0; j < iol_pkg::GRP; j++) begin : g_slot
      if (g * iol_pkg::GRP + j < Depth) begin : g_used
        assign rd_src[g][j] = cell_val[g * iol_pkg::GRP + j];
      end else begin : g_pad
        assign rd_src[g][j] = '0;
      end
    end
    always_ff @(posedge clk_i) begin
      if (accept) begin
        grp_q[g] <= rd_src[g][index_i[iol_pkg::GRP_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_ok_q <= rd_ok;
      st_q    <= status;
      hi_q    <= index_i[iol_pkg::IDX_W-1:iol_pkg::GRP_W];
    end
    if (pend_q) begin
      status_q <= st_q;
      rdval_q  <= rd_ok_q ? grp_q[hi_q] : '0;
      cnt_q    <= count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pend_q <= accept;
      done_q <= pend_q;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = rdval_q;
  assign entry_count_o = cnt_q;

endmodule
